FILE: design/sha_pkg.sv
// sha-256 constants, round functions and sequencer state type
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumHash = 8;
  localparam int unsigned NumRnd  = 64;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [3:0] LenBytes = 4'd8;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FINAL = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  typedef logic [WordW-1:0] word_t;

  localparam word_t HashInit [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [NumRnd] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sig0(word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(word_t x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(word_t e, word_t f, word_t g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(word_t a, word_t b, word_t c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: design/sha256_stream_hasher.sv
// sha-256 hasher over a byte stream, one round per cycle
`timescale 1ns / 1ps
// usage
//   slave side takes one message byte per beat: tdata[7:0] is the byte, tuser[0] says
//   whether the byte is present, tlast ends the message (a byte on the same beat is
//   absorbed first; tlast with no byte allows an empty message)
//   master side gives eight beats per message: tdata is a digest word, tuser its index
//   (0 is most significant), tlast marks the eighth word
// timing
//   the 64th byte of a block starts the compression: the rounds, then a fold
//   into the hash words; that byte holds the input until the fold is done, as
//   the single round datapath runs the rounds of a block one after another
//   at the end of a message the pad, zero fill and length are pushed one byte per
//   cycle while no compression runs (up to 72 bytes and one or two compressions),
//   then the eight digest beats
//   tready is high only while the sequencer is idle; no new beat is taken until the
//   last digest beat has gone
// reset and stall
//   reset loads the initial hash words and clears counts and the sequencer
//   a stalled receiver holds the current digest beat; the block simply waits
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  localparam int unsigned WinW = 16 * WordW;

  state_e state_q, state_d;

  // hash words, rotated during output so the word being sent always sits in front
  word_t hash_q [NumHash];
  word_t hash_d [NumHash];
  // working variables a..h
  word_t vars_q [NumHash];
  word_t vars_d [NumHash];

  // block bytes gather here and then serve as the message schedule window
  logic [WinW-1:0] win_q, win_d;
  logic [5:0]      fill_q, fill_d;
  logic [63:0]     bits_q, bits_d;
  logic [5:0]      rnd_q, rnd_d;
  logic            eom_q, eom_d;       // padding phase of the current message
  logic            pad_first_q, pad_first_d;
  logic [3:0]      len_cnt_q, len_cnt_d;
  logic [2:0]      out_idx_q, out_idx_d;

  logic            push_en;
  logic [7:0]      push_val;
  logic            block_full;
  word_t           w0, w1, w9, w14, w_new, t1, t2;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = hash_q[0];
  assign m_axis_tuser  = out_idx_q;
  assign m_axis_tlast  = (out_idx_q == 3'd7);

  // schedule taps: window holds w[t] .. w[t+15]
  assign w0    = win_q[WinW-1      -: WordW];
  assign w1    = win_q[WinW-1-32   -: WordW];
  assign w9    = win_q[WinW-1-288  -: WordW];
  assign w14   = win_q[WinW-1-448  -: WordW];
  assign w_new = w0 + small_sig0(w1) + w9 + small_sig1(w14);

  assign t1 = vars_q[7] + big_sig1(vars_q[4]) + choose(vars_q[4], vars_q[5], vars_q[6])
            + RoundK[rnd_q] + w0;
  assign t2 = big_sig0(vars_q[0]) + majority(vars_q[0], vars_q[1], vars_q[2]);

  assign block_full = push_en && (fill_q == 6'd63);

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    vars_d      = vars_q;
    win_d       = win_q;
    fill_d      = fill_q;
    bits_d      = bits_q;
    rnd_d       = rnd_q;
    eom_d       = eom_q;
    pad_first_d = pad_first_q;
    len_cnt_d   = len_cnt_q;
    out_idx_d   = out_idx_q;
    push_en     = 1'b0;
    push_val    = 8'h00;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          push_en  = s_axis_tuser[0];
          push_val = s_axis_tdata;
          if (s_axis_tuser[0]) begin
            bits_d = bits_q + 64'd8;
          end
          if (s_axis_tlast) begin
            eom_d       = 1'b1;
            pad_first_d = 1'b1;
            len_cnt_d   = '0;
            state_d     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_first_q) begin
          push_val    = PadByte;
          pad_first_d = 1'b0;
        end else if (fill_q != LenStart && len_cnt_q == '0) begin
          push_val = 8'h00;
        end else begin
          // length goes out big-endian, top byte first
          push_val  = bits_q[63:56];
          bits_d    = {bits_q[55:0], 8'h00};
          len_cnt_d = len_cnt_q + 4'd1;
        end
      end
      ST_ROUND: begin
        win_d     = {win_q[WinW-WordW-1:0], w_new};
        vars_d[0] = t1 + t2;
        vars_d[1] = vars_q[0];
        vars_d[2] = vars_q[1];
        vars_d[3] = vars_q[2];
        vars_d[4] = vars_q[3] + t1;
        vars_d[5] = vars_q[4];
        vars_d[6] = vars_q[5];
        vars_d[7] = vars_q[6];
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == 6'(NumRnd - 1)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < NumHash; i++) begin
          hash_d[i] = hash_q[i] + vars_q[i];
        end
        if (!eom_q) begin
          state_d = ST_IDLE;
        end else if (len_cnt_q == LenBytes) begin
          out_idx_d = '0;
          state_d   = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          for (int i = 0; i < NumHash - 1; i++) begin
            hash_d[i] = hash_q[i+1];
          end
          hash_d[NumHash-1] = hash_q[0];
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == 3'd7) begin
            hash_d  = HashInit;
            bits_d  = '0;
            eom_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (push_en) begin
      win_d  = {win_q[WinW-9:0], push_val};
      fill_d = fill_q + 6'd1;
    end
    // full block: load a..h and start the rounds
    if (block_full) begin
      vars_d  = hash_q;
      rnd_d   = '0;
      state_d = ST_ROUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= HashInit;
      fill_q      <= '0;
      bits_q      <= '0;
      rnd_q       <= '0;
      eom_q       <= 1'b0;
      pad_first_q <= 1'b0;
      len_cnt_q   <= '0;
      out_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      fill_q      <= fill_d;
      bits_q      <= bits_d;
      rnd_q       <= rnd_d;
      eom_q       <= eom_d;
      pad_first_q <= pad_first_d;
      len_cnt_q   <= len_cnt_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    win_q  <= win_d;
  end

endmodule

FILE: design/sha_chk.sv
// port-level checks for the sha-256 hasher, bound to the top level
`timescale 1ns / 1ps
module sha_chk
  import sha_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // no input is taken while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while digest beat pending");

  // digest words come out in index order without gaps
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
    else $error("digest index did not advance");

  // last flag marks exactly the final word
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'(NumHash - 1))))
    else $error("tlast does not match final word index");

  // after the final digest beat the block is ready for a new message
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after digest completed");

  // a stalled digest beat holds its word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled digest beat changed");

endmodule

bind sha256_stream_hasher sha_chk u_sha_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
